// File: sv/mmp64_pkg.sv
// mmp64_pkg: shared types, commands and constants for the Montgomery unit.
// No dependencies; used by mmp64_ctrl, mmp64_dp and montgomery_mul_and_pow_64.
package mmp64_pkg;

	localparam int WORD_BITS = 64;
	localparam int CNT_W     = $clog2(2 * WORD_BITS);

	localparam logic [CNT_W-1:0] LAST_MUL = CNT_W'(WORD_BITS - 1);
	localparam logic [CNT_W-1:0] LAST_DBL = CNT_W'(2 * WORD_BITS - 1);
	localparam logic [63:0]      MOD_RESET = 64'd3;

	typedef enum logic [1:0] {
		OP_MUL   = 2'd0,
		OP_ENTER = 2'd1,
		OP_POW   = 2'd2,
		OP_NONE  = 2'd3
	} op_code_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [63:0] operand_a;
		logic [63:0] operand_b;
	} in_word_t;

	typedef struct packed {
		logic [63:0] result;
		logic        bad_modulus;
	} out_word_t;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_LOAD_IN,
		DP_DBL_INIT,
		DP_DBL_STEP,
		DP_RED_A,
		DP_RED_B,
		DP_RED_STEP,
		DP_MM_AB,
		DP_MM_AR2,
		DP_MM_ONE,
		DP_MM_PA,
		DP_MM_AA,
		DP_MM_STEP,
		DP_SAVE_A,
		DP_SAVE_B,
		DP_SAVE_R2,
		DP_SAVE_ONE,
		DP_SAVE_RES,
		DP_RES_ONE,
		DP_RES_ZERO,
		DP_EXP_SHIFT
	} dp_op_t;

	typedef enum logic [1:0] {
		PUR_ONE,
		PUR_RES,
		PUR_PMUL,
		PUR_SQ
	} purpose_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DBL_INIT,
		S_DBL,
		S_R2_SAVE,
		S_ONE_START,
		S_MUL,
		S_MUL_SAVE,
		S_DISPATCH,
		S_RED,
		S_RED_SAVE,
		S_REDB_START,
		S_MMOP_START,
		S_POW,
		S_POW_SHIFT,
		S_SQ_START,
		S_DONE
	} state_t;

	typedef struct packed {
		dp_op_t op;
		logic   out_load;
	} cmd_t;

	typedef struct packed {
		logic exp_zero;
		logic exp_gt1;
		logic exp_lsb;
		logic n_even;
	} status_t;

endpackage

// File: sv/montgomery_mul_and_pow_64.sv
// Montgomery unit, R = 2^64: multiply, enter and power operations.
// One item at a time; each product is 64 steps of a shared radix-2 unit.
// First item after reset or a modulus write first derives R^2 and one, unless the modulus is even.
// Async active-low reset: modulus 3, derived constants marked stale.
// Result goes to an output register; the next word is taken as soon as the
// sequencer is back in idle, even while that result still waits.
module montgomery_mul_and_pow_64 (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mmp64_pkg::in_word_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mmp64_pkg::out_word_t out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [63:0]          cfg_data
);

	// modulus register; a write marks R^2 and Montgomery one stale
	logic [63:0]        mod_q;
	logic               cfg_we;
	mmp64_pkg::cmd_t    cmd;
	mmp64_pkg::status_t st;

	assign cfg_we = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mod_q <= mmp64_pkg::MOD_RESET;
		else if (cfg_we)
			mod_q <= cfg_data;
	end

	// sequencer: derivation (128 doublings, one product), operand remainders
	// (64 steps each), then the product or square-and-multiply loop
	mmp64_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_op     (in_data.op),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_we    (cfg_we),
		.cfg_ready (cfg_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// registers and the bit-serial add/compare logic
	mmp64_dp u_dp (
		.clk      (clk),
		.cmd      (cmd),
		.in_data  (in_data),
		.modulus  (mod_q),
		.st       (st),
		.out_data (out_data)
	);

`ifndef SYNTH
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.bad_modulus |-> out_data.result == 64'd0)
		else $error("even modulus word carries a non-zero result");

	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.bad_modulus |->
			out_data.result[mmp64_pkg::WORD_BITS-1:0] < mod_q[mmp64_pkg::WORD_BITS-1:0])
		else $error("result word not below the modulus");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while busy");
`endif

endmodule

// File: sv/mmp64_dp.sv
// mmp64_dp: datapath - operand registers, derived constants, the shared
// bit-serial Montgomery / doubling / reduction unit and the output register.
// Depends on mmp64_pkg.
module mmp64_dp (
	input  logic                 clk,
	input  mmp64_pkg::cmd_t      cmd,
	input  mmp64_pkg::in_word_t  in_data,
	input  logic [63:0]          modulus,
	output mmp64_pkg::status_t   st,
	output mmp64_pkg::out_word_t out_data
);

	localparam int W = mmp64_pkg::WORD_BITS;

	logic [W-1:0] n;
	logic [W-1:0] a_q, b_q, e_q, r2_q, one_q, res_q, sh_q, md_q;
	logic [W:0]   t_q;
	mmp64_pkg::out_word_t out_q;

	logic [W:0]   dr_in, dr_out, fin;
	logic [W+1:0] s1, s2;
	logic [W-1:0] fin_w, one_x;

	assign n = modulus[W-1:0];

	// shift-in and conditional subtract: doubling and long remainder
	assign dr_in  = {t_q[W-1:0], (cmd.op == mmp64_pkg::DP_RED_STEP) ? sh_q[W-1] : 1'b0};
	assign dr_out = (dr_in >= {1'b0, n}) ? dr_in - {1'b0, n} : dr_in;

	// radix-2 Montgomery step, t stays below 2n
	assign s1 = {1'b0, t_q} + (sh_q[0] ? {2'b00, md_q} : '0);
	assign s2 = s1 + (s1[0] ? {2'b00, n} : '0);

	assign fin   = (t_q >= {1'b0, n}) ? t_q - {1'b0, n} : t_q;
	assign fin_w = fin[W-1:0];
	assign one_x = (n == W'(1)) ? '0 : W'(1);

	always_ff @(posedge clk) begin
		case (cmd.op)
			mmp64_pkg::DP_LOAD_IN: begin
				a_q <= in_data.operand_a[W-1:0];
				b_q <= in_data.operand_b[W-1:0];
				e_q <= in_data.operand_b[W-1:0];
			end
			mmp64_pkg::DP_DBL_INIT: t_q <= {1'b0, one_x};
			mmp64_pkg::DP_DBL_STEP: t_q <= dr_out;
			mmp64_pkg::DP_RED_A: begin
				t_q  <= '0;
				sh_q <= a_q;
			end
			mmp64_pkg::DP_RED_B: begin
				t_q  <= '0;
				sh_q <= b_q;
			end
			mmp64_pkg::DP_RED_STEP: begin
				t_q  <= dr_out;
				sh_q <= {sh_q[W-2:0], 1'b0};
			end
			mmp64_pkg::DP_MM_AB: begin
				t_q <= '0; sh_q <= a_q; md_q <= b_q;
			end
			mmp64_pkg::DP_MM_AR2: begin
				t_q <= '0; sh_q <= a_q; md_q <= r2_q;
			end
			mmp64_pkg::DP_MM_ONE: begin
				t_q <= '0; sh_q <= one_x; md_q <= r2_q;
			end
			mmp64_pkg::DP_MM_PA: begin
				t_q <= '0; sh_q <= res_q; md_q <= a_q;
			end
			mmp64_pkg::DP_MM_AA: begin
				t_q <= '0; sh_q <= a_q; md_q <= a_q;
			end
			mmp64_pkg::DP_MM_STEP: begin
				t_q  <= s2[W+1:1];
				sh_q <= {1'b0, sh_q[W-1:1]};
			end
			mmp64_pkg::DP_SAVE_A:    a_q   <= fin_w;
			mmp64_pkg::DP_SAVE_B:    b_q   <= fin_w;
			mmp64_pkg::DP_SAVE_R2:   r2_q  <= fin_w;
			mmp64_pkg::DP_SAVE_ONE:  one_q <= fin_w;
			mmp64_pkg::DP_SAVE_RES:  res_q <= fin_w;
			mmp64_pkg::DP_RES_ONE:   res_q <= one_q;
			mmp64_pkg::DP_RES_ZERO:  res_q <= '0;
			mmp64_pkg::DP_EXP_SHIFT: e_q   <= {1'b0, e_q[W-1:1]};
			default: ;
		endcase
		if (cmd.out_load) begin
			out_q.result      <= 64'(res_q);
			out_q.bad_modulus <= ~n[0];
		end
	end

	assign st.exp_zero = (e_q == '0);
	assign st.exp_gt1  = |e_q[W-1:1];
	assign st.exp_lsb  = e_q[0];
	assign st.n_even   = ~n[0];
	assign out_data    = out_q;

endmodule

// File: sv/mmp64_ctrl.sv
// mmp64_ctrl: sequencer for derivation, operand reduction and the three ops.
// Depends on mmp64_pkg; drives mmp64_dp through cmd_t, reads status_t.
module mmp64_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         in_op,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  logic               cfg_we,
	output logic               cfg_ready,
	input  mmp64_pkg::status_t st,
	output mmp64_pkg::cmd_t    cmd
);

	mmp64_pkg::state_t   state_q, state_d;
	mmp64_pkg::purpose_t pur_q, pur_d;
	logic [mmp64_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic [1:0] op_q, op_d;
	logic red_b_q, red_b_d, derived_q, derived_d, out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mmp64_pkg::S_IDLE;
			pur_q       <= mmp64_pkg::PUR_RES;
			cnt_q       <= '0;
			op_q        <= '0;
			red_b_q     <= 1'b0;
			derived_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			pur_q       <= pur_d;
			cnt_q       <= cnt_d;
			op_q        <= op_d;
			red_b_q     <= red_b_d;
			derived_q   <= derived_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		pur_d        = pur_q;
		cnt_d        = cnt_q;
		op_d         = op_q;
		red_b_d      = red_b_q;
		derived_d    = derived_q;
		cmd.op       = mmp64_pkg::DP_NOP;
		cmd.out_load = 1'b0;
		in_ready     = (state_q == mmp64_pkg::S_IDLE);
		cfg_ready    = (state_q == mmp64_pkg::S_IDLE) && !out_valid_q;
		if (cfg_we)
			derived_d = 1'b0;
		case (state_q)
			mmp64_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.op = mmp64_pkg::DP_LOAD_IN;
					op_d   = in_op;
					// a modulus written at this same edge makes the derived values stale
					state_d = (!cfg_we && (derived_q || st.n_even)) ? mmp64_pkg::S_DISPATCH
					                                                : mmp64_pkg::S_DBL_INIT;
				end
			end
			mmp64_pkg::S_DBL_INIT: begin
				cmd.op  = mmp64_pkg::DP_DBL_INIT;
				cnt_d   = '0;
				state_d = mmp64_pkg::S_DBL;
			end
			mmp64_pkg::S_DBL: begin
				cmd.op = mmp64_pkg::DP_DBL_STEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == mmp64_pkg::LAST_DBL)
					state_d = mmp64_pkg::S_R2_SAVE;
			end
			mmp64_pkg::S_R2_SAVE: begin
				cmd.op  = mmp64_pkg::DP_SAVE_R2;
				state_d = mmp64_pkg::S_ONE_START;
			end
			mmp64_pkg::S_ONE_START: begin
				cmd.op  = mmp64_pkg::DP_MM_ONE;
				pur_d   = mmp64_pkg::PUR_ONE;
				cnt_d   = '0;
				state_d = mmp64_pkg::S_MUL;
			end
			mmp64_pkg::S_MUL: begin
				cmd.op = mmp64_pkg::DP_MM_STEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == mmp64_pkg::LAST_MUL)
					state_d = mmp64_pkg::S_MUL_SAVE;
			end
			mmp64_pkg::S_MUL_SAVE: begin
				case (pur_q)
					mmp64_pkg::PUR_ONE: begin
						cmd.op  = mmp64_pkg::DP_SAVE_ONE;
						state_d = mmp64_pkg::S_DISPATCH;
					end
					mmp64_pkg::PUR_RES: begin
						cmd.op  = mmp64_pkg::DP_SAVE_RES;
						state_d = mmp64_pkg::S_DONE;
					end
					mmp64_pkg::PUR_PMUL: begin
						cmd.op  = mmp64_pkg::DP_SAVE_RES;
						state_d = mmp64_pkg::S_POW_SHIFT;
					end
					default: begin
						cmd.op  = mmp64_pkg::DP_SAVE_A;
						state_d = mmp64_pkg::S_POW;
					end
				endcase
			end
			mmp64_pkg::S_DISPATCH: begin
				derived_d = 1'b1;
				if (st.n_even || op_q == mmp64_pkg::OP_NONE) begin
					cmd.op  = mmp64_pkg::DP_RES_ZERO;
					state_d = mmp64_pkg::S_DONE;
				end else begin
					cmd.op  = mmp64_pkg::DP_RED_A;
					pur_d   = mmp64_pkg::PUR_RES;
					red_b_d = 1'b0;
					cnt_d   = '0;
					state_d = mmp64_pkg::S_RED;
				end
			end
			mmp64_pkg::S_RED: begin
				cmd.op = mmp64_pkg::DP_RED_STEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == mmp64_pkg::LAST_MUL)
					state_d = mmp64_pkg::S_RED_SAVE;
			end
			mmp64_pkg::S_RED_SAVE: begin
				if (red_b_q) begin
					cmd.op  = mmp64_pkg::DP_SAVE_B;
					state_d = mmp64_pkg::S_MMOP_START;
				end else begin
					cmd.op = mmp64_pkg::DP_SAVE_A;
					if (op_q == mmp64_pkg::OP_MUL)
						state_d = mmp64_pkg::S_REDB_START;
					else if (op_q == mmp64_pkg::OP_ENTER)
						state_d = mmp64_pkg::S_MMOP_START;
					else
						state_d = mmp64_pkg::S_POW_SHIFT;
				end
			end
			mmp64_pkg::S_REDB_START: begin
				cmd.op  = mmp64_pkg::DP_RED_B;
				red_b_d = 1'b1;
				cnt_d   = '0;
				state_d = mmp64_pkg::S_RED;
			end
			mmp64_pkg::S_MMOP_START: begin
				cmd.op  = (op_q == mmp64_pkg::OP_MUL) ? mmp64_pkg::DP_MM_AB
				                                      : mmp64_pkg::DP_MM_AR2;
				pur_d   = mmp64_pkg::PUR_RES;
				cnt_d   = '0;
				state_d = mmp64_pkg::S_MUL;
			end
			mmp64_pkg::S_POW: begin
				if (st.exp_zero) begin
					state_d = mmp64_pkg::S_DONE;
				end else if (st.exp_lsb) begin
					cmd.op  = mmp64_pkg::DP_MM_PA;
					pur_d   = mmp64_pkg::PUR_PMUL;
					cnt_d   = '0;
					state_d = mmp64_pkg::S_MUL;
				end else begin
					state_d = mmp64_pkg::S_POW_SHIFT;
				end
			end
			mmp64_pkg::S_POW_SHIFT: begin
				// first entry comes from the operand reduction: seed res with one
				if (pur_q != mmp64_pkg::PUR_PMUL && pur_q != mmp64_pkg::PUR_SQ) begin
					cmd.op  = mmp64_pkg::DP_RES_ONE;
					pur_d   = mmp64_pkg::PUR_SQ;
					state_d = mmp64_pkg::S_POW;
				end else begin
					cmd.op  = mmp64_pkg::DP_EXP_SHIFT;
					state_d = st.exp_gt1 ? mmp64_pkg::S_SQ_START : mmp64_pkg::S_DONE;
				end
			end
			mmp64_pkg::S_SQ_START: begin
				cmd.op  = mmp64_pkg::DP_MM_AA;
				pur_d   = mmp64_pkg::PUR_SQ;
				cnt_d   = '0;
				state_d = mmp64_pkg::S_MUL;
			end
			mmp64_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = mmp64_pkg::S_IDLE;
				end
			end
			default: state_d = mmp64_pkg::S_IDLE;
		endcase
		if (cmd.out_load)
			out_valid_d = 1'b1;
		else if (out_ready)
			out_valid_d = 1'b0;
		else
			out_valid_d = out_valid_q;
	end

	assign out_valid = out_valid_q;

endmodule
